// ===== hw/rtl/qvr_pkg.sv =====
// shared types, constants and fixed-point helpers for the quaternion rotator
package qvr_pkg;

    localparam int unsigned QVR_FX_W      = 32;
    localparam int unsigned QVR_FRAC_BITS = 16;
    localparam int unsigned QVR_TERMS     = 8;

    localparam logic QVR_CMD_ROT = 1'b0;
    localparam logic QVR_CMD_INV = 1'b1;

    typedef logic signed [QVR_FX_W-1:0]   t_fx;
    typedef logic signed [2*QVR_FX_W-1:0] t_fx_wide;

    typedef struct packed {
        t_fx x;
        t_fx y;
        t_fx z;
    } t_vec;

    typedef struct packed {
        t_fx ww;
        t_fx xx;
        t_fx yy;
        t_fx zz;
        t_fx wx;
        t_fx wy;
        t_fx wz;
        t_fx xy;
        t_fx xz;
        t_fx yz;
    } t_quat_prod;

    typedef t_fx [QVR_TERMS-1:0] t_term_row;

    typedef struct packed {
        t_term_row x;
        t_term_row y;
        t_term_row z;
    } t_terms;

    // full product, arithmetic shift by the fraction width, keep low word
    function automatic t_fx fx_mul(t_fx a, t_fx b, int unsigned frac);
        t_fx_wide p;
        p = t_fx_wide'(a) * t_fx_wide'(b);
        return t_fx'(p >>> frac);
    endfunction

    // multiply by fixed-point two; the constant wraps negative at the widest fraction
    function automatic t_fx fx_dbl(t_fx t, logic neg);
        t_fx d;
        d = t <<< 1;
        return neg ? -d : d;
    endfunction

endpackage

// ===== hw/rtl/qvr_req_if.sv =====
// request channel: quaternion, vector and direction
interface qvr_req_if;
    import qvr_pkg::*;

    logic valid;
    logic ready;
    t_fx  quat_w;
    t_fx  quat_x;
    t_fx  quat_y;
    t_fx  quat_z;
    t_fx  vec_x;
    t_fx  vec_y;
    t_fx  vec_z;
    logic cmd;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, cmd,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, cmd,
        output ready
    );
endinterface

// ===== hw/rtl/qvr_rsp_if.sv =====
// response channel: rotated vector
interface qvr_rsp_if;
    import qvr_pkg::*;

    logic valid;
    logic ready;
    t_fx  out_x;
    t_fx  out_y;
    t_fx  out_z;

    modport source (
        output valid, out_x, out_y, out_z,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z,
        output ready
    );
endinterface

// ===== hw/rtl/quaternion_vector_rotate.sv =====
// top level of the fixed-point quaternion vector rotator
//
// i_req carries a quaternion (quat_w..quat_z), a vector (vec_x..vec_z) and cmd;
// cmd selects rotation by the quaternion or by its conjugate. o_rsp returns the
// rotated vector (out_x..out_y..out_z), one response per request, in order.
// All values are signed 32-bit fixed point with FRAC_BITS fraction bits; every
// product is truncated toward minus infinity and every sum wraps.
// The datapath is four register stages: a request passes through all four, in
// order, before its response appears with o_rsp.valid.
// The quaternion pair multipliers, the vector term multipliers, the partial
// adders and the final adders each hold one register stage.
// Throughput is one request per cycle while o_rsp.ready is high; each stage has
// its own valid bit and loads whenever it is empty or the stage after it moves on.
// When the receiver holds o_rsp.ready low the output register keeps its
// response, the stages behind it fill up, and i_req.ready drops only once all
// four stages hold a request. Nothing is dropped or repeated.
// Reset (synchronous, active low) empties all stages.
module quaternion_vector_rotate #(
    parameter int unsigned FRAC_BITS = qvr_pkg::QVR_FRAC_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    qvr_req_if.sink   i_req,
    qvr_rsp_if.source o_rsp
);
    import qvr_pkg::*;

    t_vec       req_vec;
    t_quat_prod quat_prod;
    t_vec       prod_vec;
    t_terms     terms;
    t_vec       rsp_vec;
    logic       quat_valid;
    logic       quat_ready;
    logic       term_valid;
    logic       term_ready;
    logic       part_valid;

    assign req_vec.x = i_req.vec_x;
    assign req_vec.y = i_req.vec_y;
    assign req_vec.z = i_req.vec_z;

    qvr_quat_prod #(
        .FRAC_BITS (FRAC_BITS)
    ) u_quat_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_qw    (i_req.quat_w),
        .i_qx    (i_req.quat_x),
        .i_qy    (i_req.quat_y),
        .i_qz    (i_req.quat_z),
        .i_vec   (req_vec),
        .i_cmd   (i_req.cmd),
        .o_valid (quat_valid),
        .i_ready (quat_ready),
        .o_prod  (quat_prod),
        .o_vec   (prod_vec)
    );

    qvr_vec_prod #(
        .FRAC_BITS (FRAC_BITS)
    ) u_vec_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (quat_valid),
        .o_ready (quat_ready),
        .i_prod  (quat_prod),
        .i_vec   (prod_vec),
        .o_valid (term_valid),
        .i_ready (term_ready),
        .o_terms (terms)
    );

    qvr_sum u_sum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (term_valid),
        .o_ready      (term_ready),
        .i_terms      (terms),
        .o_part_valid (part_valid),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_vec        (rsp_vec)
    );

    assign o_rsp.out_x = rsp_vec.x;
    assign o_rsp.out_y = rsp_vec.y;
    assign o_rsp.out_z = rsp_vec.z;

    // backpressure reaches the input only with every stage occupied
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (quat_valid && term_valid && part_valid && o_rsp.valid))
        else $error("request blocked while a stage is empty");

    // a finished partial sum reaches the output register when the receiver takes
    a_part_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (part_valid && o_rsp.ready) |=> o_rsp.valid)
        else $error("partial sum lost on the way to the output");

    // reset leaves every stage empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!quat_valid && !term_valid && !part_valid && !o_rsp.valid))
        else $error("stage valid set after reset");

    // an accepted request always occupies the first stage next cycle
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> quat_valid)
        else $error("accepted request not held in first stage");
endmodule

// ===== hw/rtl/qvr_quat_prod.sv =====
// stage one: optional conjugate and the ten quaternion pair products
module qvr_quat_prod #(
    parameter int unsigned FRAC_BITS = qvr_pkg::QVR_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  qvr_pkg::t_fx        i_qw,
    input  qvr_pkg::t_fx        i_qx,
    input  qvr_pkg::t_fx        i_qy,
    input  qvr_pkg::t_fx        i_qz,
    input  qvr_pkg::t_vec       i_vec,
    input  logic                i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output qvr_pkg::t_quat_prod o_prod,
    output qvr_pkg::t_vec       o_vec
);
    import qvr_pkg::*;

    logic       r_valid;
    t_quat_prod r_prod;
    t_vec       r_vec;
    t_quat_prod n_prod;
    t_fx        qx;
    t_fx        qy;
    t_fx        qz;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        qx = (i_cmd == QVR_CMD_INV) ? -i_qx : i_qx;
        qy = (i_cmd == QVR_CMD_INV) ? -i_qy : i_qy;
        qz = (i_cmd == QVR_CMD_INV) ? -i_qz : i_qz;
        n_prod.ww = fx_mul(i_qw, i_qw, FRAC_BITS);
        n_prod.xx = fx_mul(qx, qx, FRAC_BITS);
        n_prod.yy = fx_mul(qy, qy, FRAC_BITS);
        n_prod.zz = fx_mul(qz, qz, FRAC_BITS);
        n_prod.wx = fx_mul(i_qw, qx, FRAC_BITS);
        n_prod.wy = fx_mul(i_qw, qy, FRAC_BITS);
        n_prod.wz = fx_mul(i_qw, qz, FRAC_BITS);
        n_prod.xy = fx_mul(qx, qy, FRAC_BITS);
        n_prod.xz = fx_mul(qx, qz, FRAC_BITS);
        n_prod.yz = fx_mul(qy, qz, FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
            r_vec  <= i_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_vec   = r_vec;
endmodule

// ===== hw/rtl/qvr_vec_prod.sv =====
// stage two: the twenty-four vector terms of the rotation sums
module qvr_vec_prod #(
    parameter int unsigned FRAC_BITS = qvr_pkg::QVR_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  qvr_pkg::t_quat_prod i_prod,
    input  qvr_pkg::t_vec       i_vec,
    output logic                o_valid,
    input  logic                i_ready,
    output qvr_pkg::t_terms     o_terms
);
    import qvr_pkg::*;

    localparam logic DBL_NEG = (FRAC_BITS >= QVR_FX_W - 2);

    logic   r_valid;
    t_terms r_terms;
    t_terms n_terms;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_terms.x[0] = fx_mul(i_prod.ww, i_vec.x, FRAC_BITS);
        n_terms.x[1] = fx_dbl(fx_mul(i_prod.wy, i_vec.z, FRAC_BITS), DBL_NEG);
        n_terms.x[2] = fx_dbl(fx_mul(i_prod.wz, i_vec.y, FRAC_BITS), DBL_NEG);
        n_terms.x[3] = fx_mul(i_prod.xx, i_vec.x, FRAC_BITS);
        n_terms.x[4] = fx_dbl(fx_mul(i_prod.xy, i_vec.y, FRAC_BITS), DBL_NEG);
        n_terms.x[5] = fx_dbl(fx_mul(i_prod.xz, i_vec.z, FRAC_BITS), DBL_NEG);
        n_terms.x[6] = fx_mul(i_prod.zz, i_vec.x, FRAC_BITS);
        n_terms.x[7] = fx_mul(i_prod.yy, i_vec.x, FRAC_BITS);

        n_terms.y[0] = fx_dbl(fx_mul(i_prod.xy, i_vec.x, FRAC_BITS), DBL_NEG);
        n_terms.y[1] = fx_mul(i_prod.yy, i_vec.y, FRAC_BITS);
        n_terms.y[2] = fx_dbl(fx_mul(i_prod.yz, i_vec.z, FRAC_BITS), DBL_NEG);
        n_terms.y[3] = fx_dbl(fx_mul(i_prod.wz, i_vec.x, FRAC_BITS), DBL_NEG);
        n_terms.y[4] = fx_mul(i_prod.zz, i_vec.y, FRAC_BITS);
        n_terms.y[5] = fx_mul(i_prod.ww, i_vec.y, FRAC_BITS);
        n_terms.y[6] = fx_dbl(fx_mul(i_prod.wx, i_vec.z, FRAC_BITS), DBL_NEG);
        n_terms.y[7] = fx_mul(i_prod.xx, i_vec.y, FRAC_BITS);

        n_terms.z[0] = fx_dbl(fx_mul(i_prod.xz, i_vec.x, FRAC_BITS), DBL_NEG);
        n_terms.z[1] = fx_dbl(fx_mul(i_prod.yz, i_vec.y, FRAC_BITS), DBL_NEG);
        n_terms.z[2] = fx_mul(i_prod.zz, i_vec.z, FRAC_BITS);
        n_terms.z[3] = fx_dbl(fx_mul(i_prod.wy, i_vec.x, FRAC_BITS), DBL_NEG);
        n_terms.z[4] = fx_mul(i_prod.yy, i_vec.z, FRAC_BITS);
        n_terms.z[5] = fx_dbl(fx_mul(i_prod.wx, i_vec.y, FRAC_BITS), DBL_NEG);
        n_terms.z[6] = fx_mul(i_prod.xx, i_vec.z, FRAC_BITS);
        n_terms.z[7] = fx_mul(i_prod.ww, i_vec.z, FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_valid;
    assign o_terms = r_terms;
endmodule

// ===== hw/rtl/qvr_sum.sv =====
// stages three and four: partial sums, then final sums into the output register
module qvr_sum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qvr_pkg::t_terms i_terms,
    output logic            o_part_valid,
    output logic            o_valid,
    input  logic            i_ready,
    output qvr_pkg::t_vec   o_vec
);
    import qvr_pkg::*;

    logic r_part_valid;
    logic r_valid;
    t_vec r_part_lo;
    t_vec r_part_hi;
    t_vec r_out;
    t_vec n_part_lo;
    t_vec n_part_hi;
    t_vec n_out;
    logic out_ready;

    assign out_ready = !r_valid || i_ready;
    assign o_ready   = !r_part_valid || out_ready;

    always_comb begin
        n_part_lo.x = i_terms.x[0] + i_terms.x[1] - i_terms.x[2] + i_terms.x[3];
        n_part_hi.x = i_terms.x[4] + i_terms.x[5] - i_terms.x[6] - i_terms.x[7];
        n_part_lo.y = i_terms.y[0] + i_terms.y[1] + i_terms.y[2] + i_terms.y[3];
        n_part_hi.y = i_terms.y[5] - i_terms.y[4] - i_terms.y[6] - i_terms.y[7];
        n_part_lo.z = i_terms.z[0] + i_terms.z[1] + i_terms.z[2] - i_terms.z[3];
        n_part_hi.z = i_terms.z[5] + i_terms.z[7] - i_terms.z[4] - i_terms.z[6];
    end

    always_comb begin
        n_out.x = r_part_lo.x + r_part_hi.x;
        n_out.y = r_part_lo.y + r_part_hi.y;
        n_out.z = r_part_lo.z + r_part_hi.z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_part_valid <= i_valid;
            end
            if (out_ready) begin
                r_valid <= r_part_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_part_lo <= n_part_lo;
            r_part_hi <= n_part_hi;
        end
        if (out_ready && r_part_valid) begin
            r_out <= n_out;
        end
    end

    assign o_part_valid = r_part_valid;
    assign o_valid      = r_valid;
    assign o_vec        = r_out;
endmodule
